// ----- hdl/ihs_decorrelation_stretch_macros.svh -----
// ----------------------------------------------------------------------------
// IHS decorrelation stretch assertion macros
// Shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef IHS_DECORRELATION_STRETCH_MACROS_SVH
`define IHS_DECORRELATION_STRETCH_MACROS_SVH

// implication checked outside reset
`define IHSDS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ihs_decorrelation_stretch: assertion failed");

// condition in the cycle after reset is applied
`define IHSDS_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("ihs_decorrelation_stretch: reset assertion failed");

`endif

// ----- hdl/ihsds_pkg.sv -----
// ----------------------------------------------------------------------------
// IHS decorrelation stretch package
// Payload types, chain cell types and fixed constants
// ----------------------------------------------------------------------------
package ihsds_pkg;

  // field widths
  localparam int IX_W    = 27;
  localparam int Q_W     = 19;
  localparam int DVD_W   = 43;
  localparam int RAD_W   = 44;
  localparam int ROOT_W  = 22;
  localparam int SREM_W  = 24;
  localparam int QUO2_W  = 34;
  localparam int DIV_STEPS  = DVD_W;
  localparam int SQRT_STEPS = RAD_W / 2;

  // widths of the split divide by 765 in the front end
  localparam int WN_W   = 27;  // weight product magnitude
  localparam int A_W    = 18;  // coarse quotient of the weight
  localparam int B_W    = 10;  // remainder of the weight
  localparam int PB_W   = 26;  // gain times remainder
  localparam int RCP_W  = 28;  // reciprocal width
  localparam int RCP_SH = 37;  // reciprocal scale
  localparam int C_W    = PB_W + RCP_W - RCP_SH;

  // register indexes
  localparam logic [2:0] REG_REPLACE_INTENSITY = 3'd0;
  localparam logic [2:0] REG_STRETCH_INTENSITY = 3'd1;
  localparam logic [2:0] REG_SAT_MODE          = 3'd2;
  localparam logic [2:0] REG_INTENSITY_GAIN    = 3'd3;
  localparam logic [2:0] REG_INTENSITY_OFFSET  = 3'd4;
  localparam logic [2:0] REG_SAT_GAIN          = 3'd5;
  localparam logic [2:0] REG_SAT_OFFSET        = 3'd6;

  // saturation modes
  localparam logic [1:0] SAT_NONE      = 2'd0;
  localparam logic [1:0] SAT_UNIFORM   = 2'd1;
  localparam logic [1:0] SAT_INTENSITY = 2'd2;

  // arithmetic constants
  localparam logic [DVD_W-1:0] DIVIDEND_INV = 43'h600_0000_0000;  // 6 * 2^40
  localparam int               SAT_DIV      = 765;
  // ceil(2^37 / 765), exact floor for operands below 2^27
  localparam logic [RCP_W-1:0] RECIP765     = RCP_W'((64'd1 << RCP_SH) / SAT_DIV + 1);
  localparam int               WDEN         = 3133440;
  localparam int               HALF_DEN     = 50331648;  // 3 * 2^24
  localparam int               CLAMP_HI     = 98303;
  localparam int               CLAMP_OFF    = 98304;
  localparam logic [19:0]      RECIP3       = 20'd699051; // ceil(2^21 / 3)

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] new_intensity;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_red;
    logic signed [15:0] out_green;
    logic signed [15:0] out_blue;
  } out_t;

  typedef struct packed {
    logic               replace_intensity;
    logic               stretch_intensity;
    logic [1:0]         sat_mode;
    logic [15:0]        intensity_gain;
    logic signed [13:0] intensity_offset;
    logic [15:0]        sat_gain;
    logic signed [13:0] sat_offset;
  } cfg_t;

  // per-pixel sideband carried along the chains
  typedef struct packed {
    logic signed [IX_W-1:0] ix;
    logic signed [10:0]     u;
    logic signed [8:0]      v;
    logic                   qz;
    logic                   neg;
    logic [Q_W-1:0]         divisor;
  } ctx_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [DVD_W-1:0]  dvd1;
    logic [Q_W-1:0]    rem1;
    logic [QUO2_W-1:0] quo2;
  } div_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [QUO2_W-1:0] quo2;
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] srem;
    logic [ROOT_W-1:0] root;
  } sqr_t;

endpackage

// ----- hdl/ihsds_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider chain cell
// One restoring quotient bit of the inverse saturation division
// ----------------------------------------------------------------------------
module ihsds_div_cell import ihsds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic            v;
  div_t            d;
  div_t            d_next;
  logic [Q_W:0]    t1;
  logic            b1;

  // one quotient bit
  always_comb begin
    d_next = in_data;
    t1 = {in_data.rem1, in_data.dvd1[DVD_W-1]};
    b1 = t1 >= {1'b0, in_data.ctx.divisor};
    d_next.rem1 = b1 ? Q_W'(t1 - {1'b0, in_data.ctx.divisor}) : t1[Q_W-1:0];
    d_next.dvd1 = {in_data.dvd1[DVD_W-2:0], b1};
  end

  // stage handshake
  assign in_ready = !v || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d <= d_next;
    end
  end

  assign out_valid = v;
  assign out_data  = d;

endmodule

// ----- hdl/ihsds_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root chain cell
// One root bit per cell, two radicand bits consumed
// ----------------------------------------------------------------------------
module ihsds_sqrt_cell import ihsds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sqr_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output sqr_t out_data
);

  logic              v;
  sqr_t              d;
  sqr_t              d_next;
  logic [SREM_W+1:0] t;
  logic [SREM_W+1:0] trial;
  logic              ge;

  // digit recurrence step
  always_comb begin
    d_next = in_data;
    t = {in_data.srem, in_data.rad[RAD_W-1 -: 2]};
    trial = {2'b00, in_data.root, 2'b01};
    ge = t >= trial;
    d_next.srem = ge ? SREM_W'(t - trial) : t[SREM_W-1:0];
    d_next.root = {in_data.root[ROOT_W-2:0], ge};
    d_next.rad  = {in_data.rad[RAD_W-3:0], 2'b00};
  end

  // stage handshake
  assign in_ready = !v || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d <= d_next;
    end
  end

  assign out_valid = v;
  assign out_data  = d;

endmodule

// ----- hdl/ihsds_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Intensity, chroma pair, saturation weight product; seeds the divider chain
// ----------------------------------------------------------------------------
module ihsds_front import ihsds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;
  ctx_t c1, c2, c3, c4;
  ctx_t c1_next;
  ctx_t c3_next;
  logic signed [IX_W:0] wn2;
  logic signed [IX_W:0] wn2_next;
  logic [WN_W-1:0]      wabs3;
  logic [WN_W-1:0]      wabs3_next;
  logic [A_W-1:0]       a3;
  logic [A_W-1:0]       a3_next;
  logic [QUO2_W-1:0]    pa4;
  logic [QUO2_W-1:0]    pa4_next;
  logic [PB_W-1:0]      pb4;
  logic [PB_W-1:0]      pb4_next;
  div_t d5;
  div_t d5_next;

  logic [9:0]            i3;
  logic signed [IX_W-1:0] off_ext;
  logic [9:0]            ua;
  logic [7:0]            va;
  logic [Q_W-1:0]        q;
  logic signed [IX_W:0]  dev;
  logic [WN_W+RCP_W-1:0] qa;
  logic [B_W-1:0]        b;
  logic [PB_W+RCP_W-1:0] qc;

  // stage 1: intensity and chroma
  always_comb begin
    c1_next = '0;
    i3 = cfg.replace_intensity ?
         10'({2'b00, in_data.new_intensity} + {1'b0, in_data.new_intensity, 1'b0}) :
         10'({2'b00, in_data.red} + {2'b00, in_data.green} + {2'b00, in_data.blue});
    off_ext = IX_W'(cfg.intensity_offset);
    c1_next.ix = cfg.stretch_intensity ?
                 IX_W'($signed(IX_W'(cfg.intensity_gain * i3)) + off_ext * 27'sd768) :
                 $signed(IX_W'({i3, 12'b0}));
    c1_next.u = $signed({2'b00, in_data.blue, 1'b0}) - $signed({3'b000, in_data.red})
                - $signed({3'b000, in_data.green});
    c1_next.v = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
    ua = c1_next.u[10] ? 10'(-c1_next.u) : c1_next.u[9:0];
    va = c1_next.v[8] ? 8'(-c1_next.v) : c1_next.v[7:0];
    q = Q_W'(ua * ua) + Q_W'(3 * va * va);
    c1_next.qz = (q == '0);
    c1_next.divisor = c1_next.qz ? Q_W'(1) : q;
  end

  // stage 2: intensity weight
  always_comb begin
    dev = ($signed((IX_W+1)'(c1.ix)) <<< 1) - $signed((IX_W+1)'(WDEN));
    wn2_next = $signed((IX_W+1)'(WDEN)) - (dev < 0 ? -dev : dev);
  end

  // stage 3: weight magnitude and its coarse quotient by 765
  always_comb begin
    c3_next = c2;
    c3_next.neg = wn2 < 0;
    wabs3_next = (wn2 < 0) ? WN_W'(-wn2) : WN_W'(wn2);
    qa = wabs3_next * RECIP765;
    a3_next = qa[RCP_SH +: A_W];
  end

  // stage 4: gain times quotient and times remainder
  always_comb begin
    b = B_W'(wabs3 - WN_W'(a3 * SAT_DIV));
    pa4_next = QUO2_W'(cfg.sat_gain * a3);
    pb4_next = PB_W'(cfg.sat_gain * b);
  end

  // stage 5: remainder quotient, divider seed
  always_comb begin
    qc = pb4 * RECIP765;
    d5_next = '0;
    d5_next.ctx = c4;
    d5_next.dvd1 = DIVIDEND_INV;
    d5_next.quo2 = pa4 + QUO2_W'(qc[RCP_SH +: C_W]);
  end

  // stage handshakes
  assign r5 = !v5 || out_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) c1 <= c1_next;
    if (r2 && v1) begin
      c2  <= c1;
      wn2 <= wn2_next;
    end
    if (r3 && v2) begin
      c3    <= c3_next;
      wabs3 <= wabs3_next;
      a3    <= a3_next;
    end
    if (r4 && v3) begin
      c4  <= c3;
      pa4 <= pa4_next;
      pb4 <= pb4_next;
    end
    if (r5 && v4) d5 <= d5_next;
  end

  assign out_valid = v5;
  assign out_data  = d5;

endmodule

// ----- hdl/ihsds_back.sv -----
// ----------------------------------------------------------------------------
// Back end
// Chroma scale factor, RGB reconstruction, rounding and saturation
// ----------------------------------------------------------------------------
module ihsds_back import ihsds_pkg::*; #(
  parameter int FRAC_BITS = 4
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  sqr_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int XW = 51 + FRAC_BITS;
  localparam int YW = XW - 24;

  logic va, vb, vc, vd;
  logic ra, rb, rc, rd;

  logic signed [36:0]     ka, ka_next;
  logic signed [11:0]     cra, cga, cba;
  logic signed [IX_W-1:0] ixa, ixb;
  logic signed [48:0]     pr, pg, pb;
  logic [17:0]            yr, yg, yb;
  out_t                   od, od_next;

  logic signed [36:0] base;
  logic signed [36:0] offt;
  logic signed [11:0] u12, v12;
  logic               use_sat;

  // round half up by 6 * 2^24, then clamp and bias for the final divide by 3
  function automatic logic [17:0] finish(input logic signed [49:0] n);
    logic signed [XW-1:0] x;
    logic signed [YW-1:0] y;
    x = (XW'(n) <<< FRAC_BITS) + XW'(HALF_DEN);
    y = YW'(x >>> 25);
    if (y > YW'(CLAMP_HI)) y = YW'(CLAMP_HI);
    if (y < -YW'(CLAMP_OFF)) y = -YW'(CLAMP_OFF);
    return 18'(y + YW'(CLAMP_OFF));
  endfunction

  // exact divide by 3 of the biased value, bias removed
  function automatic logic signed [15:0] div3(input logic [17:0] yp);
    logic [37:0] p;
    p = 38'(yp) * 38'(RECIP3);
    return $signed(16'(p[37:21] - 17'd32768));
  endfunction

  // stage a: scale factor k
  always_comb begin
    use_sat = (cfg.sat_mode == SAT_UNIFORM) || (cfg.sat_mode == SAT_INTENSITY);
    case (cfg.sat_mode)
      SAT_UNIFORM:   base = $signed({9'b0, cfg.sat_gain, 12'b0});
      SAT_INTENSITY: base = in_data.ctx.neg ? -$signed({3'b0, in_data.quo2}) :
                                              $signed({3'b0, in_data.quo2});
      default:       base = 37'sd16777216;
    endcase
    offt = (use_sat && !in_data.ctx.qz) ?
           37'($signed(cfg.sat_offset) * $signed({1'b0, in_data.root})) : '0;
    ka_next = base + offt;
    u12 = 12'(in_data.ctx.u);
    v12 = 12'(in_data.ctx.v);
  end

  // stage handshakes
  assign rd = !vd || out_ready;
  assign rc = !vc || rd;
  assign rb = !vb || rc;
  assign ra = !va || rb;
  assign in_ready = ra;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (ra) va <= in_valid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
      if (rd) vd <= vc;
    end
  end

  // output of stage d
  always_comb begin
    od_next.out_red   = div3(yr);
    od_next.out_green = div3(yg);
    od_next.out_blue  = div3(yb);
  end

  always_ff @(posedge clk) begin
    if (ra && in_valid) begin
      ka  <= ka_next;
      cra <= (v12 <<< 1) + v12 - u12;
      cga <= -u12 - (v12 <<< 1) - v12;
      cba <= u12 <<< 1;
      ixa <= in_data.ctx.ix;
    end
    // stage b: chroma products
    if (rb && va) begin
      pr  <= ka * cra;
      pg  <= ka * cga;
      pb  <= ka * cba;
      ixb <= ixa;
    end
    // stage c: add intensity, round and clamp
    if (rc && vb) begin
      yr <= finish((50'(ixb) <<< 13) + 50'(pr));
      yg <= finish((50'(ixb) <<< 13) + 50'(pg));
      yb <= finish((50'(ixb) <<< 13) + 50'(pb));
    end
    if (rd && vc) od <= od_next;
  end

  assign out_valid = vd;
  assign out_data  = od;

endmodule

// ----- hdl/ihs_decorrelation_stretch.sv -----
// ----------------------------------------------------------------------------
// IHS decorrelation stretch
// Pixel pipeline: front end, divider cell row, square root cell row, back end
// ----------------------------------------------------------------------------
// Usage:
//  in_valid/in_ready transfer one RGB pixel plus a replacement intensity byte.
//  out_valid/out_ready transfer one stretched RGB result, signed, FRAC_BITS
//  fraction bits, saturated to 16 bits. Every pixel gives exactly one result.
//  Throughput: one pixel per cycle unless out_ready stalls, set by the cell
//  rows that each handle one quotient bit (43 divider cells) or one root bit
//  (22 square root cells). Pipeline: 5 front stages, 43 divider cells,
//  22 root cells, 4 back stages.
//  Every stage holds its item while the next one is full; a stalled receiver
//  fills the row from the end, and bubbles keep being filled in meanwhile.
//  Configuration: cfg_write with cfg_index and cfg_data writes one register;
//  write only while no pixel is in flight. Unknown indexes are ignored.
//  Reset: synchronous; empties all stages and loads the register defaults
//  (uniform saturation stretch, gains 2.0, offsets 0).
// ----------------------------------------------------------------------------
module ihs_decorrelation_stretch import ihsds_pkg::*; #(
  parameter int FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "ihs_decorrelation_stretch_macros.svh"

  cfg_t cfg;

  logic div_v [DIV_STEPS+1];
  logic div_r [DIV_STEPS+1];
  div_t div_d [DIV_STEPS+1];
  logic sq_v  [SQRT_STEPS+1];
  logic sq_r  [SQRT_STEPS+1];
  sqr_t sq_d  [SQRT_STEPS+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.replace_intensity <= 1'b0;
      cfg.stretch_intensity <= 1'b0;
      cfg.sat_mode          <= SAT_UNIFORM;
      cfg.intensity_gain    <= 16'd8192;
      cfg.intensity_offset  <= '0;
      cfg.sat_gain          <= 16'd8192;
      cfg.sat_offset        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REPLACE_INTENSITY: cfg.replace_intensity <= cfg_data[0];
        REG_STRETCH_INTENSITY: cfg.stretch_intensity <= cfg_data[0];
        REG_SAT_MODE:          cfg.sat_mode          <= cfg_data[1:0];
        REG_INTENSITY_GAIN:    cfg.intensity_gain    <= cfg_data;
        REG_INTENSITY_OFFSET:  cfg.intensity_offset  <= $signed(cfg_data[13:0]);
        REG_SAT_GAIN:          cfg.sat_gain          <= cfg_data;
        REG_SAT_OFFSET:        cfg.sat_offset        <= $signed(cfg_data[13:0]);
        default: ;
      endcase
    end
  end

  // front end
  ihsds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (div_v[0]),
    .out_ready (div_r[0]),
    .out_data  (div_d[0])
  );

  // divider cell row
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    ihsds_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_v[i]),
      .in_ready  (div_r[i]),
      .in_data   (div_d[i]),
      .out_valid (div_v[i+1]),
      .out_ready (div_r[i+1]),
      .out_data  (div_d[i+1])
    );
  end

  // hand quotients to the root row
  always_comb begin
    sq_d[0].ctx  = div_d[DIV_STEPS].ctx;
    sq_d[0].quo2 = div_d[DIV_STEPS].quo2;
    sq_d[0].rad  = {1'b0, div_d[DIV_STEPS].dvd1};
    sq_d[0].srem = '0;
    sq_d[0].root = '0;
  end
  assign sq_v[0] = div_v[DIV_STEPS];
  assign div_r[DIV_STEPS] = sq_r[0];

  // square root cell row
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    ihsds_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[j]),
      .in_ready  (sq_r[j]),
      .in_data   (sq_d[j]),
      .out_valid (sq_v[j+1]),
      .out_ready (sq_r[j+1]),
      .out_data  (sq_d[j+1])
    );
  end

  // back end
  ihsds_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sq_v[SQRT_STEPS]),
    .in_ready  (sq_r[SQRT_STEPS]),
    .in_data   (sq_d[SQRT_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `IHSDS_ASSERT_IMP(a_full_only_when_stalled, !in_ready, out_valid && !out_ready)
  `IHSDS_ASSERT_IMP(a_zero_sat_divisor,
                    div_v[DIV_STEPS] && div_d[DIV_STEPS].ctx.qz,
                    div_d[DIV_STEPS].ctx.divisor == 19'd1)
  `IHSDS_ASSERT_RST(a_reset_empties, !out_valid)

endmodule

// ----- tb/ihs_decorrelation_stretch_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IHS decorrelation stretch checker
// Watches both channels, predicts each stretched pixel from the register
// settings seen at the write port, and compares results in order
// ----------------------------------------------------------------------------
module ihs_decorrelation_stretch_checker import ihsds_pkg::*; #(
  parameter int FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  cfg_t cfg;
  out_t pixel_queue[$];

  assign pending = pixel_queue.size();

  // integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // round half up to FRAC_BITS and saturate to 16 bits
  function automatic logic signed [15:0] round_sat(longint n);
    longint den, num, r;
    den = longint'(6) << 24;
    num = n * (longint'(1) << FRAC_BITS) + den / 2;
    r = num / den;
    if ((num % den) != 0 && num < 0) r--;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic out_t stretch_pixel(in_t px, cfg_t c);
    longint r, g, b, i3, ix, u, v, q, k, dev, wn;
    longint unsigned inv;
    out_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    i3 = c.replace_intensity ? 3 * longint'(px.new_intensity) : r + g + b;
    ix = c.stretch_intensity ?
         longint'(c.intensity_gain) * i3 + longint'(c.intensity_offset) * 768 : 4096 * i3;
    u = 2 * b - r - g;
    v = r - g;
    q = u * u + 3 * v * v;
    if (c.sat_mode == SAT_UNIFORM || c.sat_mode == SAT_INTENSITY) begin
      if (c.sat_mode == SAT_UNIFORM) begin
        k = longint'(c.sat_gain) * 4096;
      end else begin
        dev = 2 * ix - WDEN;
        if (dev < 0) dev = -dev;
        wn = WDEN - dev;
        k = (longint'(c.sat_gain) * wn * 4096) / WDEN;
      end
      if (q > 0) begin
        inv = root_floor((64'd6 << 40) / longint'(q));
        k += longint'(c.sat_offset) * longint'(inv);
      end
    end else begin
      k = longint'(1) << 24;
    end
    res.out_red   = round_sat(8192 * ix + k * (3 * v - u));
    res.out_green = round_sat(8192 * ix + k * (-u - 3 * v));
    res.out_blue  = round_sat(8192 * ix + k * (2 * u));
    return res;
  endfunction

  // shadow registers, input prediction, output compare
  always @(posedge clk) begin
    out_t exp_px;
    if (rst) begin
      cfg.replace_intensity <= 1'b0;
      cfg.stretch_intensity <= 1'b0;
      cfg.sat_mode          <= SAT_UNIFORM;
      cfg.intensity_gain    <= 16'd8192;
      cfg.intensity_offset  <= '0;
      cfg.sat_gain          <= 16'd8192;
      cfg.sat_offset        <= '0;
      pixel_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_REPLACE_INTENSITY: cfg.replace_intensity <= cfg_data[0];
          REG_STRETCH_INTENSITY: cfg.stretch_intensity <= cfg_data[0];
          REG_SAT_MODE:          cfg.sat_mode          <= cfg_data[1:0];
          REG_INTENSITY_GAIN:    cfg.intensity_gain    <= cfg_data;
          REG_INTENSITY_OFFSET:  cfg.intensity_offset  <= cfg_data[13:0];
          REG_SAT_GAIN:          cfg.sat_gain          <= cfg_data;
          REG_SAT_OFFSET:        cfg.sat_offset        <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pixel_queue.push_back(stretch_pixel(in_data, cfg));
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected result transfer %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_px = pixel_queue.pop_front();
          if (out_data.out_red !== exp_px.out_red) begin
            $error("out_red expected %0d actual %0d", exp_px.out_red, out_data.out_red);
            fail_count <= fail_count + 1;
          end else if (out_data.out_green !== exp_px.out_green) begin
            $error("out_green expected %0d actual %0d", exp_px.out_green,
                   out_data.out_green);
            fail_count <= fail_count + 1;
          end else if (out_data.out_blue !== exp_px.out_blue) begin
            $error("out_blue expected %0d actual %0d", exp_px.out_blue, out_data.out_blue);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_ihs_decorrelation_stretch.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IHS decorrelation stretch testbench
// Drives directed and random pixels through several register settings and
// idle patterns; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_ihs_decorrelation_stretch;
  import ihsds_pkg::*;

  localparam int LATENCY   = 74;
  localparam int WDOG_MAX  = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ihs_decorrelation_stretch dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_write, .cfg_index, .cfg_data
  );

  ihs_decorrelation_stretch_checker chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_write, .cfg_index, .cfg_data, .fail_count, .pending
  );

  // receiver stall, with a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one pixel transfer, with random idle cycles ahead of it
  task automatic send_pixel(in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic in_t random_pixel();
    in_t px;
    px = $urandom;
    case ($urandom_range(5))
      0: px.green = px.red;                              // red and green equal
      1: begin px.green = px.red; px.blue = px.red; end  // zero saturation
      default: ;
    endcase
    return px;
  endfunction

  task automatic random_config();
    write_reg(REG_REPLACE_INTENSITY, 16'($urandom_range(1)));
    write_reg(REG_STRETCH_INTENSITY, 16'($urandom_range(1)));
    write_reg(REG_SAT_MODE, 16'($urandom_range(3)));
    write_reg(REG_INTENSITY_GAIN, ($urandom_range(3) == 0) ? 16'($urandom) :
              16'($urandom_range(8192)));
    write_reg(REG_INTENSITY_OFFSET, 16'($urandom));
    write_reg(REG_SAT_GAIN, ($urandom_range(3) == 0) ? 16'($urandom) :
              16'($urandom_range(16384)));
    write_reg(REG_SAT_OFFSET, ($urandom_range(1) == 0) ? 16'($urandom) :
              16'($signed(14'($urandom_range(64))) - 32));
  endtask

  initial begin
    int phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and gray pixels at reset registers, then every saturation mode
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd255, 8'd0, 8'd255});
    send_pixel('{8'd0, 8'd0, 8'd255, 8'd0});
    send_pixel('{8'd128, 8'd128, 8'd128, 8'd7});
    send_pixel('{8'd255, 8'd255, 8'd0, 8'd170});
    drain();
    write_reg(REG_SAT_MODE, {14'd0, SAT_NONE});
    send_pixel('{8'd200, 8'd10, 8'd90, 8'd55});
    send_pixel('{8'd0, 8'd255, 8'd255, 8'd0});
    drain();
    write_reg(REG_SAT_MODE, 16'd3);  // unused mode acts as none
    write_reg(REG_REPLACE_INTENSITY, 16'hFFFF);
    send_pixel('{8'd200, 8'd10, 8'd90, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd255, 8'd0});
    drain();
    write_reg(REG_SAT_MODE, {14'd0, SAT_INTENSITY});
    write_reg(REG_STRETCH_INTENSITY, 16'd1);
    write_reg(REG_INTENSITY_GAIN, 16'hFFFF);
    write_reg(REG_INTENSITY_OFFSET, 16'h1FFF);
    write_reg(REG_SAT_GAIN, 16'hFFFF);
    write_reg(REG_SAT_OFFSET, 16'h2000);
    send_pixel('{8'd255, 8'd0, 8'd0, 8'd255});
    send_pixel('{8'd10, 8'd20, 8'd30, 8'd128});
    send_pixel('{8'd77, 8'd77, 8'd77, 8'd0});
    drain();
    write_reg(REG_INTENSITY_GAIN, 16'd0);
    write_reg(REG_INTENSITY_OFFSET, 16'h2000);
    write_reg(REG_SAT_GAIN, 16'd0);
    write_reg(REG_SAT_OFFSET, 16'h1FFF);
    send_pixel('{8'd0, 8'd255, 8'd0, 8'd100});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});
    drain();

    // random phases over idle patterns
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      random_config();
      for (int n = 0; n < 110; n++) begin
        if (phase == 4 && n == 20) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send_pixel(random_pixel());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
